// ===== rtl/core/mndt_pkg.sv =====
// shared types and constants for the midi note duration tracker
package mndt_pkg;

	localparam int OPEN_NOTES = 64;
	localparam int TIME_BITS  = 32;
	localparam int IDX_W      = $clog2(OPEN_NOTES);
	localparam int CNT_W      = $clog2(OPEN_NOTES + 1);
	localparam int SPAN_W     = CNT_W + 1;

	localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
	localparam logic [3:0] KIND_NOTE_OFF = 4'h8;

	typedef enum logic [2:0] {
		OUTCOME_IGNORED   = 3'd0,
		OUTCOME_OPENED    = 3'd1,
		OUTCOME_CLOSED    = 3'd2,
		OUTCOME_UNMATCHED = 3'd3,
		OUTCOME_DROPPED   = 3'd4
	} outcome_t;

	typedef enum logic [1:0] {
		CMD_IGNORE = 2'd0,
		CMD_OPEN   = 2'd1,
		CMD_CLOSE  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		logic [7:0]  status_byte;
		logic [6:0]  key_number;
		logic [6:0]  key_velocity;
		logic [31:0] event_time;
	} in_item_t;

	typedef struct packed {
		outcome_t    outcome;
		logic [3:0]  note_channel;
		logic [6:0]  note_pitch;
		logic [6:0]  start_velocity;
		logic [31:0] start_time;
		logic [31:0] duration;
	} out_item_t;

	typedef struct packed {
		cmd_kind_t            kind;
		logic [3:0]           chan;
		logic [6:0]           pitch;
		logic [6:0]           vel;
		logic [TIME_BITS-1:0] now;
	} cmd_t;

	typedef struct packed {
		logic [3:0]           chan;
		logic [6:0]           pitch;
		logic [6:0]           vel;
		logic [TIME_BITS-1:0] start;
	} entry_t;

endpackage

// ===== rtl/core/mndt_front.sv =====
// front end: event classification and two-entry command queue
module mndt_front import mndt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t item,
	output logic     cmd_valid,
	input  logic     cmd_take,
	output cmd_t     cmd
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic [3:0] kind;
	logic       do_push;
	logic       do_pop;

	assign kind = item.status_byte[7:4];

	// note-on with zero velocity counts as a release
	always_comb begin
		cls.chan  = item.status_byte[3:0];
		cls.pitch = item.key_number;
		cls.vel   = item.key_velocity;
		cls.now   = TIME_BITS'(item.event_time);
		if (kind == KIND_NOTE_ON && item.key_velocity != 7'd0) begin
			cls.kind = CMD_OPEN;
		end else if (kind == KIND_NOTE_ON || kind == KIND_NOTE_OFF) begin
			cls.kind = CMD_CLOSE;
		end else begin
			cls.kind = CMD_IGNORE;
		end
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/core/mndt_back.sv =====
// back end: open-note table, oldest-match scan, compaction and result register
module mndt_back import mndt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_take,
	input  cmd_t      cmd,
	output logic      res_valid,
	input  logic      pop,
	output out_item_t result
);

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_SCAN_RD  = 6'b000010,
		ST_SCAN_CMP = 6'b000100,
		ST_SHIFT_RD = 6'b001000,
		ST_SHIFT_WR = 6'b010000,
		ST_EMIT     = 6'b100000
	} state_t;

	state_t           state_q, state_d;
	cmd_t             cur_q, cur_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	out_item_t        pend_q, pend_d;
	out_item_t        out_q;
	logic             out_valid_q;
	logic             out_load;

	entry_t           mem [OPEN_NOTES];
	entry_t           rd_data_q;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;

	logic [SPAN_W-1:0] idx_p1;
	logic [SPAN_W-1:0] idx_p2;
	logic [SPAN_W-1:0] cnt_w;
	logic              key_hit;

	assign idx_p1  = SPAN_W'(idx_q) + SPAN_W'(1);
	assign idx_p2  = SPAN_W'(idx_q) + SPAN_W'(2);
	assign cnt_w   = SPAN_W'(cnt_q);
	assign key_hit = (rd_data_q.chan == cur_q.chan) && (rd_data_q.pitch == cur_q.pitch);

	always_comb begin
		state_d  = state_q;
		cur_d    = cur_q;
		idx_d    = idx_q;
		cnt_d    = cnt_q;
		pend_d   = pend_q;
		cmd_take = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = idx_q;
		wr_en    = 1'b0;
		wr_addr  = idx_q;
		wr_data  = rd_data_q;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_take = 1'b1;
					cur_d    = cmd;
					pend_d   = '0;
					state_d  = ST_EMIT;
					case (cmd.kind)
						CMD_OPEN: begin
							pend_d.note_channel   = cmd.chan;
							pend_d.note_pitch     = cmd.pitch;
							pend_d.start_velocity = cmd.vel;
							pend_d.start_time     = 32'(cmd.now);
							if (cnt_q == CNT_W'(OPEN_NOTES)) begin
								pend_d.outcome = OUTCOME_DROPPED;
							end else begin
								pend_d.outcome = OUTCOME_OPENED;
								wr_en          = 1'b1;
								wr_addr        = cnt_q[IDX_W-1:0];
								wr_data.chan   = cmd.chan;
								wr_data.pitch  = cmd.pitch;
								wr_data.vel    = cmd.vel;
								wr_data.start  = cmd.now;
								cnt_d          = cnt_q + CNT_W'(1);
							end
						end
						CMD_CLOSE: begin
							pend_d.outcome      = OUTCOME_UNMATCHED;
							pend_d.note_channel = cmd.chan;
							pend_d.note_pitch   = cmd.pitch;
							idx_d               = '0;
							if (cnt_q != '0) begin
								state_d = ST_SCAN_RD;
							end
						end
						default: begin
							pend_d.outcome = OUTCOME_IGNORED;
						end
					endcase
				end
			end
			ST_SCAN_RD: begin
				rd_en   = 1'b1;
				rd_addr = idx_q;
				state_d = ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				if (key_hit) begin
					pend_d.outcome        = OUTCOME_CLOSED;
					pend_d.start_velocity = rd_data_q.vel;
					pend_d.start_time     = 32'(rd_data_q.start);
					pend_d.duration       = 32'(cur_q.now - rd_data_q.start);
					if (idx_p1 < cnt_w) begin
						state_d = ST_SHIFT_RD;
					end else begin
						cnt_d   = cnt_q - CNT_W'(1);
						state_d = ST_EMIT;
					end
				end else if (idx_p1 < cnt_w) begin
					idx_d   = idx_q + IDX_W'(1);
					state_d = ST_SCAN_RD;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_SHIFT_RD: begin
				rd_en   = 1'b1;
				rd_addr = idx_p1[IDX_W-1:0];
				state_d = ST_SHIFT_WR;
			end
			ST_SHIFT_WR: begin
				wr_en   = 1'b1;
				wr_addr = idx_q;
				wr_data = rd_data_q;
				idx_d   = idx_q + IDX_W'(1);
				if (idx_p2 < cnt_w) begin
					state_d = ST_SHIFT_RD;
				end else begin
					cnt_d   = cnt_q - CNT_W'(1);
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || pop) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// table storage, no reset: only entries below the fill count are ever read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		cur_q  <= cur_d;
		idx_q  <= idx_d;
		pend_q <= pend_d;
		if (out_load) begin
			out_q <= pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign result    = out_q;

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(OPEN_NOTES))
		else $error("fill count above table size");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (CNT_W'(wr_addr) < cnt_q || (state_q == ST_IDLE && CNT_W'(wr_addr) == cnt_q)))
		else $error("table write outside filled region");

	a_grow_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> (cnt_q <= $past(cnt_q)))
		else $error("fill count grew outside idle");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_RD || state_q == ST_SHIFT_RD) |-> (CNT_W'(idx_q) < cnt_q))
		else $error("scan index past fill count");
`endif

endmodule

// ===== rtl/core/midi_note_duration_tracker.sv =====
// top level of the midi note duration tracker
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------
//  events   | in        | push / full            | item   (in_item_t)
//  results  | out       | pop / empty            | result (out_item_t)
//
// one result per event, in event order. ignored events, opens, drops and releases
// against an empty table go from the idle state straight to the emit state.
// a release scans the table from the oldest entry, reading and then comparing each
// entry, then closes the gap behind the match by reading and rewriting each later
// entry, all through the single registered read port of the table memory.
// reset clears the fill count and queues; table contents need no clearing.
// a two-entry command queue keeps accepting events while the back end works or
// a result waits to be popped, until both of its entries are taken
module midi_note_duration_tracker import mndt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic cmd_valid;
	logic cmd_take;
	cmd_t cmd;
	logic res_valid;

	// front: classify note-on / note-off / other and queue the command
	mndt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd)
	);

	// back: table update, match search and result register
	mndt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd),
		.res_valid (res_valid),
		.pop       (pop),
		.result    (result)
	);

	// result queue looks empty until the output register holds a transfer
	assign empty = !res_valid;

endmodule
